/* src/mmuf_pkg.sv */
// shared widths and payload types of the minmod upwind flux pipeline
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
package mmuf_pkg;

    localparam int VAL_W = 32;              // stencil values, velocities, face states
    localparam int DET_W = 31;              // cell measure
    localparam int PROD_W = 2 * VAL_W;      // face flux products
    localparam int MAG_W = 2 * VAL_W;       // magnitude of the flux difference

    // values that ride along the reconstruction stages untouched
    typedef struct packed {
        logic signed [VAL_W-1:0] vel_plus;
        logic signed [VAL_W-1:0] vel_minus;
        logic [DET_W-1:0]        measure;
    } t_side;

    // reconstructed face states, already clamped to 32 bits
    typedef struct packed {
        logic signed [VAL_W-1:0] u11;
        logic signed [VAL_W-1:0] u10;
        logic signed [VAL_W-1:0] u01;
        logic signed [VAL_W-1:0] u00;
    } t_faces;

    // flux difference split into sign and magnitude for the divider
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [DET_W-1:0] measure;
    } t_quot_in;

endpackage

/* src/mmuf_recon.sv */
// stencil differences, limited slopes and face state reconstruction
// depends on mmuf_pkg; the divide by six is a reciprocal multiply followed by a shift
`timescale 1ns / 1ps
module mmuf_recon
    import mmuf_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [VAL_W-1:0] i_center_value,
    input  logic signed [VAL_W-1:0] i_plus_near,
    input  logic signed [VAL_W-1:0] i_plus_far,
    input  logic signed [VAL_W-1:0] i_minus_near,
    input  logic signed [VAL_W-1:0] i_minus_far,
    input  t_side                   i_side,
    output logic                    o_valid,
    output t_faces                  o_faces,
    output t_side                   o_side
);

    localparam int D_W = VAL_W + 1;     // stencil difference
    localparam int G_W = VAL_W + 2;     // limited slope
    localparam int N_W = VAL_W + 4;     // ga + 2*gb
    localparam int X_W = VAL_W + 3;     // |n| + 3
    localparam int NFACE = 4;
    localparam int S_W = VAL_W + 4;     // base plus increment
    // x < 2^34, so x/2 fits 33 bits and floor(x/6) = floor((x/2) * ceil(2^33/3) / 2^33)
    localparam int Y_W = X_W - 2;
    localparam int R_W = 32;
    localparam int R_SH = 33;
    localparam int P_W = Y_W + R_W;
    localparam logic [R_W-1:0] RECIP3 = 32'hAAAA_AAAB;

    localparam logic signed [S_W-1:0] POS_MAX = {{(S_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    localparam logic signed [S_W-1:0] NEG_MAX = {{(S_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

    function automatic logic signed [G_W-1:0] lim(
        input logic signed [D_W-1:0] a,
        input logic signed [D_W-1:0] b
    );
        logic [D_W-1:0] ma;
        logic [D_W+1:0] mb4;
        logic [D_W+1:0] m;
        logic signed [G_W-1:0] res;
        ma  = a[D_W-1] ? D_W'(-a) : D_W'(a);
        mb4 = b[D_W-1] ? {D_W'(-b), 2'b00} : {D_W'(b), 2'b00};
        m   = ({2'b00, ma} < mb4) ? {2'b00, ma} : mb4;
        if (a == '0 || b == '0 || a[D_W-1] != b[D_W-1]) begin
            res = '0;
        end else if (a[D_W-1]) begin
            res = -$signed(m[G_W-1:0]);
        end else begin
            res = $signed(m[G_W-1:0]);
        end
        return res;
    endfunction

    function automatic logic signed [VAL_W-1:0] clamp(input logic signed [S_W-1:0] v);
        logic signed [VAL_W-1:0] res;
        if (v > POS_MAX) begin
            res = POS_MAX[VAL_W-1:0];
        end else if (v < NEG_MAX) begin
            res = NEG_MAX[VAL_W-1:0];
        end else begin
            res = v[VAL_W-1:0];
        end
        return res;
    endfunction

    // stage 1: differences
    logic                    r_v1;
    logic signed [D_W-1:0]   r_d1, r_d2, r_d3, r_d4;
    logic signed [VAL_W-1:0] r_c1, r_pn1, r_mn1;
    t_side                   r_side1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_d4    <= D_W'(i_plus_far) - D_W'(i_plus_near);
        r_d3    <= D_W'(i_plus_near) - D_W'(i_center_value);
        r_d2    <= D_W'(i_center_value) - D_W'(i_minus_near);
        r_d1    <= D_W'(i_minus_near) - D_W'(i_minus_far);
        r_c1    <= i_center_value;
        r_pn1   <= i_plus_near;
        r_mn1   <= i_minus_near;
        r_side1 <= i_side;
    end

    // stage 2: limited slopes
    logic                    r_v2;
    logic signed [G_W-1:0]   r_g1, r_g2, r_g3, r_g4, r_g5, r_g6;
    logic signed [VAL_W-1:0] r_c2, r_pn2, r_mn2;
    t_side                   r_side2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_g6    <= lim(r_d4, r_d3);
        r_g5    <= lim(r_d3, r_d4);
        r_g4    <= lim(r_d3, r_d2);
        r_g3    <= lim(r_d2, r_d3);
        r_g2    <= lim(r_d2, r_d1);
        r_g1    <= lim(r_d1, r_d2);
        r_c2    <= r_c1;
        r_pn2   <= r_pn1;
        r_mn2   <= r_mn1;
        r_side2 <= r_side1;
    end

    // stage 3: per face, |n| + 3 ahead of the divide by six
    // face order: u11, u10, u01, u00
    logic signed [N_W-1:0] n_num [NFACE];
    logic [NFACE-1:0]      n_sub;
    logic signed [VAL_W-1:0] n_base [NFACE];

    always_comb begin
        n_num[0] = N_W'(r_g6) + (N_W'(r_g5) <<< 1);
        n_num[1] = N_W'(r_g3) + (N_W'(r_g4) <<< 1);
        n_num[2] = N_W'(r_g4) + (N_W'(r_g3) <<< 1);
        n_num[3] = N_W'(r_g1) + (N_W'(r_g2) <<< 1);
        n_sub    = 4'b0101;
        n_base[0] = r_pn2;
        n_base[1] = r_c2;
        n_base[2] = r_c2;
        n_base[3] = r_mn2;
    end

    logic                    r_dv;
    t_side                   r_dside;
    logic [X_W-1:0]          r_dx    [NFACE];
    logic                    r_dneg  [NFACE];
    logic signed [VAL_W-1:0] r_dbase [NFACE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
        end else begin
            r_dv <= r_v2;
        end
        r_dside <= r_side2;
        for (int f = 0; f < NFACE; f++) begin
            r_dx[f]    <= n_num[f][N_W-1] ? X_W'(-n_num[f]) + X_W'(3)
                                          : X_W'(n_num[f]) + X_W'(3);
            r_dneg[f]  <= n_num[f][N_W-1] ^ n_sub[f];
            r_dbase[f] <= n_base[f];
        end
    end

    // stage 4: reciprocal product of x/2
    logic                    r_mv;
    t_side                   r_mside;
    logic [P_W-1:0]          r_mp    [NFACE];
    logic                    r_mneg  [NFACE];
    logic signed [VAL_W-1:0] r_mbase [NFACE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else begin
            r_mv <= r_dv;
        end
        r_mside <= r_dside;
        for (int f = 0; f < NFACE; f++) begin
            r_mp[f]    <= P_W'(r_dx[f][X_W-2:1]) * P_W'(RECIP3);
            r_mneg[f]  <= r_dneg[f];
            r_mbase[f] <= r_dbase[f];
        end
    end

    // last stage: base plus or minus increment, clamp
    logic signed [VAL_W-1:0] n_u [NFACE];

    always_comb begin
        logic signed [S_W-1:0] inc;
        for (int f = 0; f < NFACE; f++) begin
            inc    = r_mneg[f] ? -$signed(S_W'(r_mp[f][P_W-1:R_SH]))
                               : $signed(S_W'(r_mp[f][P_W-1:R_SH]));
            n_u[f] = clamp(S_W'(r_mbase[f]) + inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_mv;
        end
        o_faces.u11 <= n_u[0];
        o_faces.u10 <= n_u[1];
        o_faces.u01 <= n_u[2];
        o_faces.u00 <= n_u[3];
        o_side      <= r_mside;
    end

endmodule

/* src/mmuf_flux.sv */
// upwind selection, face flux products and their difference
// depends on mmuf_pkg; two 32x32 multipliers, then one wide subtract
`timescale 1ns / 1ps
module mmuf_flux
    import mmuf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_faces   i_faces,
    input  t_side    i_side,
    output logic     o_valid,
    output t_quot_in o_quot
);

    logic                     r_v1;
    logic signed [PROD_W-1:0] r_f1, r_f0;
    logic [DET_W-1:0]         r_meas1;
    logic signed [VAL_W-1:0]  n_up_plus, n_up_minus;
    logic signed [PROD_W:0]   n_diff;

    always_comb begin
        n_up_plus  = i_side.vel_plus[VAL_W-1]  ? i_faces.u11 : i_faces.u10;
        n_up_minus = i_side.vel_minus[VAL_W-1] ? i_faces.u01 : i_faces.u00;
        n_diff     = (PROD_W+1)'(r_f1) - (PROD_W+1)'(r_f0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1    <= i_valid;
            o_valid <= r_v1;
        end
        r_f1    <= PROD_W'(i_side.vel_plus) * PROD_W'(n_up_plus);
        r_f0    <= PROD_W'(i_side.vel_minus) * PROD_W'(n_up_minus);
        r_meas1 <= i_side.measure;
        o_quot.neg     <= n_diff[PROD_W];
        o_quot.mag     <= n_diff[PROD_W] ? MAG_W'(-n_diff) : MAG_W'(n_diff);
        o_quot.measure <= r_meas1;
    end

endmodule

/* src/mmuf_div.sv */
// pipelined restoring divider, one quotient bit per stage, with rounding and saturation
// depends on mmuf_pkg; quotients of 2^32 and up are caught before the stages
`timescale 1ns / 1ps
module mmuf_div
    import mmuf_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  t_quot_in                i_quot,
    output logic                    o_valid,
    output logic signed [VAL_W-1:0] o_flux_term,
    output logic                    o_saturated
);

    localparam int SAT_W = (DATA_WIDTH > VAL_W) ? VAL_W : DATA_WIDTH;
    localparam int Q_BITS = MAG_W - VAL_W;
    localparam int Q_W = Q_BITS + 1;
    localparam logic [Q_W-1:0] POS_LIM = (Q_W'(1) << (SAT_W - 1)) - Q_W'(1);
    localparam logic [Q_W-1:0] NEG_LIM = Q_W'(1) << (SAT_W - 1);

    logic                r_v    [Q_BITS+1];
    logic [DET_W-1:0]    r_rem  [Q_BITS+1];
    logic [Q_BITS-1:0]   r_lo   [Q_BITS+1];
    logic [DET_W-1:0]    r_det  [Q_BITS+1];
    logic                r_neg  [Q_BITS+1];
    logic                r_over [Q_BITS+1];
    logic                r_zero [Q_BITS+1];

    logic n_zero;
    assign n_zero = (i_quot.mag == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_rem[0]  <= i_quot.mag[MAG_W-2:Q_BITS];
        r_lo[0]   <= i_quot.mag[Q_BITS-1:0];
        r_det[0]  <= i_quot.measure;
        r_neg[0]  <= i_quot.neg;
        // high half at or above the measure: quotient cannot fit
        r_over[0] <= (i_quot.mag[MAG_W-1:Q_BITS] >= VAL_W'(i_quot.measure)) && !n_zero;
        r_zero[0] <= n_zero;
    end

    for (genvar s = 1; s <= Q_BITS; s++) begin : g_step
        logic [DET_W:0] n_t;
        logic           n_ge;

        assign n_t  = {r_rem[s-1], r_lo[s-1][Q_BITS-1]};
        assign n_ge = (n_t >= (DET_W+1)'(r_det[s-1]));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else begin
                r_v[s] <= r_v[s-1];
            end
            r_rem[s]  <= n_ge ? DET_W'(n_t - (DET_W+1)'(r_det[s-1])) : n_t[DET_W-1:0];
            r_lo[s]   <= {r_lo[s-1][Q_BITS-2:0], n_ge};
            r_det[s]  <= r_det[s-1];
            r_neg[s]  <= r_neg[s-1];
            r_over[s] <= r_over[s-1];
            r_zero[s] <= r_zero[s-1];
        end
    end

    logic             n_round;
    logic [Q_W-1:0]   n_q, n_lim, n_mag;
    logic             n_sat;

    always_comb begin
        // round half away from zero: 2*rem >= measure
        n_round = ({r_rem[Q_BITS], 1'b0} >= (DET_W+1)'(r_det[Q_BITS]));
        n_q     = Q_W'(r_lo[Q_BITS]) + Q_W'(n_round);
        n_lim   = r_neg[Q_BITS] ? NEG_LIM : POS_LIM;
        n_sat   = !r_zero[Q_BITS] && (r_over[Q_BITS] || (n_q > n_lim));
        if (r_zero[Q_BITS]) begin
            n_mag = '0;
        end else if (n_sat) begin
            n_mag = n_lim;
        end else begin
            n_mag = n_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v[Q_BITS];
        end
        o_flux_term <= r_neg[Q_BITS] ? VAL_W'(-n_mag) : VAL_W'(n_mag);
        o_saturated <= n_sat;
    end

endmodule

/* src/muscl_minmod_upwind_flux.sv */
// top level of the minmod upwind flux pipeline for one direction of one cell
// depends on mmuf_pkg, mmuf_recon, mmuf_flux and mmuf_div
`timescale 1ns / 1ps
// Usage:
//   Drive the five stencil values, both face velocities and the cell measure
//   (all Q16.16) and raise start for one cycle per item. busy is tied low, so
//   a transfer happens at every edge where start is high: one item per cycle.
//   Each item gives exactly one result on o_flux_term / o_saturated, shown for
//   a single cycle with o_valid high. Results come out in the order items
//   went in.
// Stage breakdown:
//   5 stages of reconstruction (differences, limiter, rounding offset,
//   reciprocal product for the divide by six, clamp), 2 stages for the flux
//   products and their difference, and 34 stages for the measure divider,
//   which resolves one quotient bit a stage.
// Throughput is one item per cycle, set by the fully pipelined divider.
// Reset (synchronous, active low) clears the valid bits of all stages; items
// in flight are dropped. The receiver cannot hold results off: it must take
// o_valid cycles as they come. DATA_WIDTH sets the saturation range, capped
// at 32 bits.
module muscl_minmod_upwind_flux
    import mmuf_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [VAL_W-1:0] i_center_value,
    input  logic signed [VAL_W-1:0] i_plus_near,
    input  logic signed [VAL_W-1:0] i_plus_far,
    input  logic signed [VAL_W-1:0] i_minus_near,
    input  logic signed [VAL_W-1:0] i_minus_far,
    input  logic signed [VAL_W-1:0] i_face_vel_plus,
    input  logic signed [VAL_W-1:0] i_face_vel_minus,
    input  logic [DET_W-1:0]        i_cell_measure,
    output logic                    o_valid,
    output logic signed [VAL_W-1:0] o_flux_term,
    output logic                    o_saturated
);

    t_side    in_side, rec_side;
    t_faces   rec_faces;
    t_quot_in quot;
    logic     rec_valid, flux_valid;

    assign busy = 1'b0;

    always_comb begin
        in_side.vel_plus  = i_face_vel_plus;
        in_side.vel_minus = i_face_vel_minus;
        in_side.measure   = i_cell_measure;
    end

    mmuf_recon u_recon (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (start),
        .i_center_value (i_center_value),
        .i_plus_near    (i_plus_near),
        .i_plus_far     (i_plus_far),
        .i_minus_near   (i_minus_near),
        .i_minus_far    (i_minus_far),
        .i_side         (in_side),
        .o_valid        (rec_valid),
        .o_faces        (rec_faces),
        .o_side         (rec_side)
    );

    mmuf_flux u_flux (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rec_valid),
        .i_faces (rec_faces),
        .i_side  (rec_side),
        .o_valid (flux_valid),
        .o_quot  (quot)
    );

    mmuf_div #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (flux_valid),
        .i_quot      (quot),
        .o_valid     (o_valid),
        .o_flux_term (o_flux_term),
        .o_saturated (o_saturated)
    );

endmodule
